// ===== hdl/quadrature_detent_decoder_core_assert.svh =====
// Assertion macros used by the checker file of the decoder.
`ifndef QUADRATURE_DETENT_DECODER_CORE_ASSERT_SVH
`define QUADRATURE_DETENT_DECODER_CORE_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted.
`define QDD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("qdd assertion failed");

// Clocked assertion that also holds during reset.
`define QDD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("qdd assertion failed");

`endif

// ===== hdl/qdd_pkg.sv =====
package qdd_pkg;

  // Input request codes
  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_UP       = 3'd1,
    OP_DOWN     = 3'd2,
    OP_PRESSED  = 3'd3,
    OP_RELEASED = 3'd4
  } op_e;

  // Pending button event
  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_PRESSED  = 2'd1,
    EV_RELEASED = 2'd2
  } ev_e;

  // Register indexes (word address paddr[3:2])
  localparam logic [1:0] REG_DETENT_PULSES = 2'd0;
  localparam logic [1:0] REG_BUTTON_ENABLE = 2'd1;
  localparam logic [1:0] REG_HOLD_TICKS    = 2'd2;

  localparam logic [7:0] DETENT_PULSES_RST = 8'd4;
  localparam logic       BUTTON_ENABLE_RST = 1'b1;
  localparam logic [7:0] HOLD_TICKS_RST    = 8'd50;

  typedef struct packed {
    logic [2:0] op;
    logic       line_a;
    logic       line_b;
    logic       button_level;
  } in_t;

  typedef struct packed {
    logic signed [15:0] position;
    logic               taken;
  } out_t;

  typedef struct packed {
    logic [7:0] detent_pulses;
    logic       button_enable;
    logic [7:0] hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         prev_lines;
    logic signed [15:0] position;
    logic [7:0]         hold_count;
    ev_e                pending;
  } state_t;

  // 4x quadrature step, indexed by {prev, now}; skipped states count 2.
  function automatic logic signed [2:0] step_delta(input logic [3:0] code);
    logic signed [2:0] d;
    unique case (code)
      4'd1, 4'd7, 4'd8, 4'd14:  d = 3'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: d = -3'sd1;
      4'd3, 4'd12:              d = 3'sd2;
      4'd6, 4'd9:               d = -3'sd2;
      default:                  d = 3'sd0;
    endcase
    return d;
  endfunction

endpackage

// ===== hdl/qdd_cfg_regs.sv =====
module qdd_cfg_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output qdd_pkg::cfg_t    cfg_o
);

  qdd_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[3:2])
        qdd_pkg::REG_DETENT_PULSES: cfg_d.detent_pulses = pwdata[7:0];
        qdd_pkg::REG_BUTTON_ENABLE: cfg_d.button_enable = pwdata[0];
        qdd_pkg::REG_HOLD_TICKS:    cfg_d.hold_ticks    = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      qdd_pkg::REG_DETENT_PULSES: prdata = {24'd0, cfg_q.detent_pulses};
      qdd_pkg::REG_BUTTON_ENABLE: prdata = {31'd0, cfg_q.button_enable};
      qdd_pkg::REG_HOLD_TICKS:    prdata = {24'd0, cfg_q.hold_ticks};
      default:                    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.detent_pulses <= qdd_pkg::DETENT_PULSES_RST;
      cfg_q.button_enable <= qdd_pkg::BUTTON_ENABLE_RST;
      cfg_q.hold_ticks    <= qdd_pkg::HOLD_TICKS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/qdd_step.sv =====
module qdd_step (
  input  qdd_pkg::in_t    item_i,
  input  qdd_pkg::state_t state_i,
  input  qdd_pkg::cfg_t   cfg_i,
  output qdd_pkg::state_t state_o,
  output qdd_pkg::out_t   result_o
);

  logic [1:0]         now;
  logic signed [2:0]  delta;
  logic signed [16:0] pos_ext;
  logic signed [16:0] det_ext;
  logic               taken;

  assign now     = {~item_i.line_b, ~item_i.line_a};
  assign delta   = qdd_pkg::step_delta({state_i.prev_lines, now});
  assign pos_ext = {state_i.position[15], state_i.position};
  assign det_ext = $signed({9'd0, cfg_i.detent_pulses});

  always_comb begin
    state_o = state_i;
    taken   = 1'b0;
    unique case (item_i.op)
      qdd_pkg::OP_TICK: begin
        state_o.position   = state_i.position + {{13{delta[2]}}, delta};
        state_o.prev_lines = now;
        if (cfg_i.button_enable) begin
          if (!item_i.button_level) begin
            // press only registers once the hold counter has run out
            if (state_i.hold_count == 8'd0) begin
              state_o.hold_count = cfg_i.hold_ticks;
              state_o.pending    = qdd_pkg::EV_PRESSED;
            end
          end else if (state_i.hold_count != 8'd0) begin
            state_o.hold_count = state_i.hold_count - 8'd1;
            if (state_i.hold_count == 8'd1) begin
              state_o.pending = qdd_pkg::EV_RELEASED;
            end
          end
        end
      end
      qdd_pkg::OP_UP: begin
        if (pos_ext >= det_ext) begin
          state_o.position = state_i.position - $signed({8'd0, cfg_i.detent_pulses});
          taken = 1'b1;
        end
      end
      qdd_pkg::OP_DOWN: begin
        if (pos_ext <= -det_ext) begin
          state_o.position = state_i.position + $signed({8'd0, cfg_i.detent_pulses});
          taken = 1'b1;
        end
      end
      qdd_pkg::OP_PRESSED: begin
        if (state_i.pending == qdd_pkg::EV_PRESSED) begin
          state_o.pending = qdd_pkg::EV_NONE;
          taken = 1'b1;
        end
      end
      qdd_pkg::OP_RELEASED: begin
        if (state_i.pending == qdd_pkg::EV_RELEASED) begin
          state_o.pending = qdd_pkg::EV_NONE;
          taken = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign result_o.position = state_o.position;
  assign result_o.taken    = taken;

endmodule

// ===== hdl/quadrature_detent_decoder_core.sv =====
// Quadrature detent decoder. Each request is a sample tick (op 0, with the
// active-low A/B and button pin levels) or a consume of a detent up, detent
// down, pressed or released event (ops 1 to 4); ops 5 to 7 change no state.
// Every request yields one result: the 16-bit wrapping position after it and
// a taken flag. The block sustains one request per clock while the output
// side does not stall. A request passes through the input register and the
// result register, and its result is held while the output side stalls. The
// rate holds because the position/button state is updated in a single pass
// between the input register and the result register. Three APB registers
// (byte addresses 0, 4, 8): detent_pulses, button_enable, hold_ticks; write
// them only while no request is in flight.
module quadrature_detent_decoder_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  // request channel
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  qdd_pkg::in_t  in_data_i,
  // result channel
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output qdd_pkg::out_t out_data_o,
  // configuration port
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  qdd_pkg::cfg_t   cfg;
  qdd_pkg::in_t    in_data_q;
  logic            in_valid_q;
  qdd_pkg::state_t state_q, state_d;
  qdd_pkg::out_t   result;
  qdd_pkg::out_t   out_data_q;
  logic            out_valid_q;
  logic            out_ready;
  logic            advance;

  qdd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Result register free, or being emptied this cycle.
  assign out_ready  = !out_valid_q || !out_stall_i;
  // Input request moves into the result register.
  assign advance    = in_valid_q && out_ready;
  // Stall only when the input register is full and cannot drain.
  assign in_stall_o = in_valid_q && !out_ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
  end

  // Single-pass state update
  qdd_step u_step (
    .item_i   (in_data_q),
    .state_i  (state_q),
    .cfg_i    (cfg),
    .state_o  (state_d),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.prev_lines <= 2'd0;
      state_q.position   <= 16'sd0;
      state_q.hold_count <= 8'd0;
      state_q.pending    <= qdd_pkg::EV_NONE;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== hdl/qdd_checker.sv =====
`include "quadrature_detent_decoder_core_assert.svh"

module qdd_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input qdd_pkg::out_t out_data_o,
  input logic          pready
);

  // a stalled result holds
  `QDD_ASSERT(a_out_hold, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))

  // input side stalls only behind a stalled, full result
  `QDD_ASSERT(a_stall_cause, in_stall_o |-> (out_valid_o && out_stall_i))

  // with no backpressure an accepted request passes through the input register into the result register
  `QDD_ASSERT(a_latency, ((in_valid_i && !in_stall_o) ##1 !out_stall_i) |=> out_valid_o)

  // config port never waits
  `QDD_ASSERT_ALWAYS(a_pready, pready)

endmodule

bind quadrature_detent_decoder_core qdd_checker u_qdd_checker (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  // Request codes the package leaves unnamed: the block must ignore them.
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  // Cycles waited after the last owed result so the pipe settles before a register write.
  localparam int DRAIN_CYCLES = 4;
  localparam int MAX_REPORTS  = 50;
  localparam int TIMEOUT_NS   = 5_000_000;

  // 4x quadrature step per {previous pair, new pair}; a skipped state moves two counts.
  localparam int QUAD_STEP [16] = '{0, 1, -1, 2, -1, 0, -2, 1, 1, -2, 0, -1, 2, -1, 1, 0};

  // Random phases: register setting, idle/stall pressure, request count.
  localparam int PHASES = 6;
  localparam int PH_DETENT [PHASES] = '{1, 4, 255, 0, 3, 7};
  localparam int PH_ENABLE [PHASES] = '{1, 1, 1, 0, 1, 1};
  localparam int PH_HOLD   [PHASES] = '{1, 5, 255, 0, 0, 3};
  localparam int PH_GAP    [PHASES] = '{0, 81, 0, 8, 0, 8};
  localparam int PH_STALL  [PHASES] = '{0, 0, 81, 8, 0, 8};
  localparam int PH_ITEMS  [PHASES] = '{120, 120, 120, 100, 100, 90};

  // Directed table: a request checked against the predictor, a request with a
  // typed-in result, or a register write.
  typedef enum logic [1:0] {
    ROW_CHECK,
    ROW_FIXED,
    ROW_WRITE
  } row_kind_e;

  typedef struct packed {
    row_kind_e     kind;
    qdd_pkg::in_t  req;
    qdd_pkg::out_t res;
    logic [1:0]    reg_idx;
    logic [7:0]    reg_val;
  } row_t;

  localparam int DIR_ROWS = 32;

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          req_valid = 1'b0;
  logic          req_stall;
  qdd_pkg::in_t  req_data  = '0;
  logic          res_valid;
  logic          res_stall = 1'b0;
  qdd_pkg::out_t res_data;
  logic          psel      = 1'b0;
  logic          penable   = 1'b0;
  logic          pwrite    = 1'b0;
  logic [3:0]    paddr     = '0;
  logic [31:0]   pwdata    = '0;
  logic [31:0]   prdata;
  logic          pready;

  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  int          mismatches     = 0;

  // Results still owed by the block, oldest first.
  qdd_pkg::out_t expected_q [$];

  // Predictor copy of the registers and of the decoder state.
  logic [7:0]         cfg_detent;
  logic               cfg_btn_en;
  logic [7:0]         cfg_hold;
  logic [1:0]         last_pair;
  logic signed [15:0] pos;
  logic [7:0]         hold;
  qdd_pkg::ev_e       pend;

  row_t dir_rows [DIR_ROWS];

  quadrature_detent_decoder_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (req_valid),
    .in_stall_o  (req_stall),
    .in_data_i   (req_data),
    .out_valid_o (res_valid),
    .out_stall_i (res_stall),
    .out_data_o  (res_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk = ~clk;

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk) begin
    res_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_REPORTS) $display("MISMATCH @%0t: %s", $time, what);
    mismatches++;
  endtask

  // Expected result of one request; advances the predictor state.
  function automatic qdd_pkg::out_t predict_result(input qdd_pkg::in_t req);
    qdd_pkg::out_t res;
    logic [1:0]    pair;
    int            p;
    res.taken = 1'b0;
    p = int'(pos);
    case (req.op)
      qdd_pkg::OP_TICK: begin
        // pins are active low, pair is {B, A} inverted
        pair = {~req.line_b, ~req.line_a};
        pos = 16'(p + QUAD_STEP[{last_pair, pair}]);
        last_pair = pair;
        if (cfg_btn_en) begin
          if (!req.button_level) begin
            // a press only counts once the hold from the last one has run out
            if (hold == 8'd0) begin
              hold = cfg_hold;
              pend = qdd_pkg::EV_PRESSED;
            end
          end else if (hold != 8'd0) begin
            hold = hold - 8'd1;
            if (hold == 8'd0) pend = qdd_pkg::EV_RELEASED;
          end
        end
      end
      qdd_pkg::OP_UP: begin
        if (p >= int'(cfg_detent)) begin
          pos = 16'(p - int'(cfg_detent));
          res.taken = 1'b1;
        end
      end
      qdd_pkg::OP_DOWN: begin
        if (p <= -int'(cfg_detent)) begin
          pos = 16'(p + int'(cfg_detent));
          res.taken = 1'b1;
        end
      end
      qdd_pkg::OP_PRESSED: begin
        if (pend == qdd_pkg::EV_PRESSED) begin
          pend = qdd_pkg::EV_NONE;
          res.taken = 1'b1;
        end
      end
      qdd_pkg::OP_RELEASED: begin
        if (pend == qdd_pkg::EV_RELEASED) begin
          pend = qdd_pkg::EV_NONE;
          res.taken = 1'b1;
        end
      end
      default: ;
    endcase
    res.position = pos;
    return res;
  endfunction

  // Offer one request (with random gaps before it) and hold it until accepted.
  task automatic send_request(input qdd_pkg::in_t req, input bit use_fixed,
                              input qdd_pkg::out_t fixed_res);
    qdd_pkg::out_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= req;
    do @(posedge clk); while (req_stall);
    predicted = predict_result(req);
    expected_q.push_back(use_fixed ? fixed_res : predicted);
  endtask

  // Stop offering requests and wait out every owed result.
  task automatic drain_results();
    @(negedge clk);
    req_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access until pready. Only done with the pipe empty.
  task automatic write_setting(input logic [1:0] idx, input logic [7:0] val);
    drain_results();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(val);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      qdd_pkg::REG_DETENT_PULSES: cfg_detent = val;
      qdd_pkg::REG_BUTTON_ENABLE: cfg_btn_en = val[0];
      qdd_pkg::REG_HOLD_TICKS:    cfg_hold   = val;
      default: ;
    endcase
  endtask

  function automatic row_t check_row(input logic [2:0] op, input logic a, input logic b,
                                     input logic btn);
    row_t r;
    r = '0;
    r.kind = ROW_CHECK;
    r.req  = '{op: op, line_a: a, line_b: b, button_level: btn};
    return r;
  endfunction

  function automatic row_t fixed_row(input logic [2:0] op, input logic a, input logic b,
                                     input logic btn, input logic signed [15:0] p,
                                     input logic tk);
    row_t r;
    r = check_row(op, a, b, btn);
    r.kind = ROW_FIXED;
    r.res  = '{position: p, taken: tk};
    return r;
  endfunction

  function automatic row_t write_row(input logic [1:0] idx, input logic [7:0] val);
    row_t r;
    r = '0;
    r.kind    = ROW_WRITE;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // Results must match the oldest expectation field by field.
  always @(posedge clk) begin : check_results
    qdd_pkg::out_t want;
    if (rst_n && res_valid && !res_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing owed: position %0d taken %0b",
                                  res_data.position, res_data.taken));
      end else begin
        want = expected_q.pop_front();
        if (res_data.position !== want.position)
          report_mismatch($sformatf("position %0d, expected %0d",
                                    res_data.position, want.position));
        if (res_data.taken !== want.taken)
          report_mismatch($sformatf("taken %0b, expected %0b", res_data.taken, want.taken));
      end
    end
  end

  initial begin : stimulus
    qdd_pkg::in_t req;
    logic [1:0]   rot_pair;
    logic         rot_up;
    logic         btn_low;
    int           btn_run;
    int           pick;
    int           r;

    // predictor starts from the reset state
    cfg_detent = qdd_pkg::DETENT_PULSES_RST;
    cfg_btn_en = qdd_pkg::BUTTON_ENABLE_RST;
    cfg_hold   = qdd_pkg::HOLD_TICKS_RST;
    last_pair  = 2'b00;
    pos        = '0;
    hold       = 8'd0;
    pend       = qdd_pkg::EV_NONE;
    rot_pair   = 2'b00;
    rot_up     = 1'b1;
    btn_low    = 1'b0;
    btn_run    = 0;

    dir_rows = '{
      // straight after reset: nothing to take, no motion
      fixed_row(qdd_pkg::OP_UP,       1'b1, 1'b1, 1'b1, 16'sd0, 1'b0),
      fixed_row(qdd_pkg::OP_DOWN,     1'b1, 1'b1, 1'b1, 16'sd0, 1'b0),
      fixed_row(qdd_pkg::OP_PRESSED,  1'b1, 1'b1, 1'b1, 16'sd0, 1'b0),
      fixed_row(qdd_pkg::OP_RELEASED, 1'b1, 1'b1, 1'b1, 16'sd0, 1'b0),
      fixed_row(OP_SPARE_LAST,        1'b0, 1'b0, 1'b0, 16'sd0, 1'b0),
      fixed_row(qdd_pkg::OP_TICK,     1'b1, 1'b1, 1'b1, 16'sd0, 1'b0),
      // one full forward cycle, then a detent up
      check_row(qdd_pkg::OP_TICK,     1'b0, 1'b1, 1'b1),
      check_row(qdd_pkg::OP_TICK,     1'b0, 1'b0, 1'b1),
      check_row(qdd_pkg::OP_TICK,     1'b1, 1'b0, 1'b1),
      check_row(qdd_pkg::OP_TICK,     1'b1, 1'b1, 1'b1),
      check_row(qdd_pkg::OP_UP,       1'b1, 1'b1, 1'b1),
      // skipped state counts two
      check_row(qdd_pkg::OP_TICK,     1'b0, 1'b0, 1'b1),
      check_row(qdd_pkg::OP_DOWN,     1'b0, 1'b0, 1'b1),
      // press, take it, release after a short hold
      write_row(qdd_pkg::REG_HOLD_TICKS, 8'd2),
      check_row(qdd_pkg::OP_TICK,     1'b1, 1'b1, 1'b0),
      check_row(qdd_pkg::OP_PRESSED,  1'b1, 1'b1, 1'b0),
      check_row(qdd_pkg::OP_TICK,     1'b1, 1'b1, 1'b1),
      check_row(qdd_pkg::OP_RELEASED, 1'b1, 1'b1, 1'b1),
      check_row(qdd_pkg::OP_TICK,     1'b1, 1'b1, 1'b1),
      check_row(qdd_pkg::OP_RELEASED, 1'b1, 1'b1, 1'b1),
      // zero detent: takes do not move the position; up is taken, down is not as the position is above zero
      write_row(qdd_pkg::REG_DETENT_PULSES, 8'd0),
      check_row(qdd_pkg::OP_UP,       1'b0, 1'b1, 1'b1),
      check_row(qdd_pkg::OP_DOWN,     1'b1, 1'b0, 1'b1),
      // zero hold: every pressed tick raises pressed again
      write_row(qdd_pkg::REG_HOLD_TICKS, 8'd0),
      check_row(qdd_pkg::OP_TICK,     1'b1, 1'b1, 1'b0),
      check_row(qdd_pkg::OP_PRESSED,  1'b1, 1'b1, 1'b0),
      check_row(qdd_pkg::OP_TICK,     1'b1, 1'b1, 1'b0),
      check_row(qdd_pkg::OP_PRESSED,  1'b1, 1'b1, 1'b0),
      // button off: the pin is ignored
      write_row(qdd_pkg::REG_BUTTON_ENABLE, 8'd0),
      check_row(qdd_pkg::OP_TICK,     1'b1, 1'b1, 1'b0),
      check_row(qdd_pkg::OP_PRESSED,  1'b1, 1'b1, 1'b0),
      check_row(OP_SPARE_FIRST,       1'b0, 1'b1, 1'b0)
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_WRITE: write_setting(dir_rows[i].reg_idx, dir_rows[i].reg_val);
        ROW_FIXED: send_request(dir_rows[i].req, 1'b1, dir_rows[i].res);
        default:   send_request(dir_rows[i].req, 1'b0, '0);
      endcase
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      write_setting(qdd_pkg::REG_DETENT_PULSES, 8'(PH_DETENT[ph]));
      write_setting(qdd_pkg::REG_BUTTON_ENABLE, 8'(PH_ENABLE[ph]));
      write_setting(qdd_pkg::REG_HOLD_TICKS, 8'(PH_HOLD[ph]));
      send_gap_pct   = PH_GAP[ph];
      recv_stall_pct = PH_STALL[ph];

      for (int n = 0; n < PH_ITEMS[ph]; n++) begin
        pick = $urandom_range(99);
        req.op           = 3'($urandom_range(7));
        req.line_a       = 1'($urandom_range(1));
        req.line_b       = 1'($urandom_range(1));
        req.button_level = 1'($urandom_range(1));
        if (pick < 60) begin
          // Mostly clean gray-code rotation, with reversals, skips, dwell and noise.
          req.op = qdd_pkg::OP_TICK;
          if ($urandom_range(9) == 0) rot_up = ~rot_up;
          r = $urandom_range(9);
          if (r < 7)
            rot_pair = rot_up ? {rot_pair[0], ~rot_pair[1]} : {~rot_pair[0], rot_pair[1]};
          else if (r == 7)
            rot_pair = rot_pair ^ 2'b11;
          else if (r == 9)
            rot_pair = 2'($urandom_range(3));
          req.line_a = ~rot_pair[0];
          req.line_b = ~rot_pair[1];
          // Button held in runs; released runs sometimes outlast the hold count.
          if (btn_run == 0) begin
            btn_low = ~btn_low;
            btn_run = btn_low ? $urandom_range(4, 1) : $urandom_range(int'(cfg_hold) + 6, 1);
          end
          btn_run--;
          req.button_level = ~btn_low;
        end else if (pick < 95) begin
          req.op = 3'($urandom_range(int'(qdd_pkg::OP_RELEASED), int'(qdd_pkg::OP_UP)));
        end else begin
          req.op = 3'($urandom_range(int'(OP_SPARE_LAST), int'(OP_SPARE_FIRST)));
        end
        send_request(req, 1'b0, '0);
      end
    end

    drain_results();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hang guard.
  initial begin
    #(TIMEOUT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
